// ===== sv/fgr_pkg.sv =====
// -----------------------------------------------------------------------------
// fgr_pkg
// Shared constants, codes and types of the frame-to-grid resampler.
// -----------------------------------------------------------------------------
package fgr_pkg;

   localparam int MAX_FRAMES_DEF = 64;

   // item kinds
   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [1:0] ST_FEW       = 2'd2;

   // register indexes
   localparam logic CSR_UNITS = 1'b0;
   localparam logic CSR_MODE  = 1'b1;

   localparam logic MODE_LINEAR = 1'b0;
   localparam logic MODE_CONST  = 1'b1;

   // divider widths
   localparam int DVD_W = 81;
   localparam int DVS_W = 34;
   localparam int QUO_W = 35;
   localparam int CNT_W = 7;
   localparam logic [QUO_W-1:0] QCAP = 35'h4_0000_0000;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } fgr_div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
      logic             inexact;
   } fgr_div_rsp_type;

endpackage

// ===== sv/fgr_req_if.sv =====
// -----------------------------------------------------------------------------
// fgr_req_if
// Input item channel: frame loads, sample requests and clears.
// -----------------------------------------------------------------------------
interface fgr_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [31:0]       frame_start;
   logic [31:0]       frame_end;
   logic signed [31:0] frame_value;

   modport source (output valid, kind, frame_start, frame_end, frame_value, input ready);
   modport sink   (input valid, kind, frame_start, frame_end, frame_value, output ready);
endinterface

// ===== sv/fgr_rsp_if.sv =====
// -----------------------------------------------------------------------------
// fgr_rsp_if
// Result item channel: one grid sample per request.
// -----------------------------------------------------------------------------
interface fgr_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] sample_value;
   logic [31:0] sample_index;
   logic        last_sample;
   logic [1:0]  status;

   modport source (output valid, sample_value, sample_index, last_sample, status,
                   input ready);
   modport sink   (input valid, sample_value, sample_index, last_sample, status,
                   output ready);
endinterface

// ===== sv/frame_to_grid_resampler.sv =====
// -----------------------------------------------------------------------------
// frame_to_grid_resampler
// Stores timed frames and returns one-second grid samples on request.
// -----------------------------------------------------------------------------
// One item at a time. A frame load, a clear or an unknown kind is handled
// in the idle state. A sample request first runs the status checks, then
// in linear mode steps the cursor over frames (a read and a compare per
// frame), reads the frame pair, runs a shift-add multiply and waits on the
// divider (a start, the bit-serial quotient steps, a done strobe); in const
// mode it walks the frames from the newest down, ruling out some frames at
// once and passing the others through the divider. The final state then
// hands the result to the output register. The frame memory (one write port,
// one registered read port) and the bit-serial divider shape these steps.
// A finished result sits in the output register; loads are taken while it
// waits, the next request completes once it has been taken.
// The frame memory has no reset; only entries below the frame count are used.
module frame_to_grid_resampler #(
   parameter int MAX_FRAMES = fgr_pkg::MAX_FRAMES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   fgr_req_if.sink     req,
   fgr_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_FRAMES);
   localparam int NUM_W = $clog2(MAX_FRAMES + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHK   = 4'd1;
   localparam logic [3:0] S_LRD   = 4'd2;
   localparam logic [3:0] S_LCMP  = 4'd3;
   localparam logic [3:0] S_LV1   = 4'd4;
   localparam logic [3:0] S_LV2   = 4'd5;
   localparam logic [3:0] S_LMUL  = 4'd6;
   localparam logic [3:0] S_LDIVS = 4'd7;
   localparam logic [3:0] S_LDIV  = 4'd8;
   localparam logic [3:0] S_CRD   = 4'd9;
   localparam logic [3:0] S_CCHK  = 4'd10;
   localparam logic [3:0] S_CDIV  = 4'd11;
   localparam logic [3:0] S_CCMP  = 4'd12;
   localparam logic [3:0] S_FIN   = 4'd13;

   // frame memory: {value, end, start}
   logic [95:0]      store_mem [MAX_FRAMES];
   logic [95:0]      rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;

   logic [3:0]       state_ff, state_in;
   logic [15:0]      units_ff, units_in;
   logic             mode_ff, mode_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [31:0]      j_ff, j_in;
   logic [31:0]      last_end_ff, last_end_in;
   logic [48:0]      tl_ff, tl_in;       // (2j+1)*R, sample time doubled
   logic [32:0]      m1_ff, m1_in;
   logic [31:0]      y1_ff, y1_in;
   logic [33:0]      dmag_ff, dmag_in;
   logic             neg_ff, neg_in;
   logic signed [36:0] y_ff, y_in;
   logic             last_ff, last_in;
   logic [1:0]       status_ff, status_in;
   logic [80:0]      acc_ff, acc_in;
   logic [80:0]      mcand_ff, mcand_in;
   logic [31:0]      mplier_ff, mplier_in;
   logic [4:0]       mcnt_ff, mcnt_in;
   logic [NUM_W-1:0] cidx_ff, cidx_in;
   logic [31:0]      cs_ff, cs_in;
   logic [31:0]      ce_ff, ce_in;
   logic [31:0]      cv_ff, cv_in;
   logic [50:0]      kr_ff, kr_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [30:0]      rsp_value_ff, rsp_value_in;
   logic [31:0]      rsp_index_ff, rsp_index_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;

   fgr_pkg::fgr_div_req_type div_req;
   fgr_pkg::fgr_div_rsp_type div_rsp;

   logic [15:0] r_eff;
   logic [16:0] r2;
   logic [32:0] e2;
   logic        slot_free;
   logic [NUM_W:0] cur_p2;
   // per-state work values
   logic [32:0] m_rd, m2;
   logic [32:0] dy;
   logic        nneg, dneg, yneg;
   logic [48:0] nmag;
   logic [31:0] s_rd;
   logic [32:0] s2;
   logic [49:0] lim;
   logic        need_div;
   logic [49:0] cdvd;
   logic [36:0] y1x, qx;

   fgr_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign r_eff     = (units_ff == '0) ? 16'd1 : units_ff;
   assign r2        = {r_eff, 1'b0};
   assign e2        = {last_end_ff, 1'b0};
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign cur_p2    = (NUM_W+1)'(cur_ff) + (NUM_W+1)'(2);
   assign req.ready = state_ff == S_IDLE;

   always_comb begin
      // frame read for the const walk; frame 0 start raised to one second
      s_rd     = rd_ff[31:0];
      if (cidx_ff == '0 && s_rd < {16'd0, r_eff}) s_rd = {16'd0, r_eff};
      s2       = {s_rd, 1'b0};
      lim      = {1'b0, tl_ff} + {33'd0, r2};
      need_div = (state_ff == S_CCHK) && ({17'd0, s2} < lim) && ({16'd0, s2} < tl_ff);
      cdvd     = {1'b0, tl_ff} - {17'd0, s2} + {33'd0, r2} - 50'd1;

      div_req.start    = (state_ff == S_LDIVS) || need_div;
      div_req.dividend = (state_ff == S_LDIVS) ? acc_ff : {31'd0, cdvd};
      div_req.divisor  = (state_ff == S_LDIVS) ? dmag_ff : {17'd0, r2};

      m_rd = {1'b0, rd_ff[31:0]} + {1'b0, rd_ff[63:32]};
      m2   = m_rd;
      dy   = {rd_ff[95], rd_ff[95:64]} - {y1_ff[31], y1_ff};
      nneg = tl_ff < {16'd0, m1_ff};
      nmag = nneg ? {16'd0, m1_ff} - tl_ff : tl_ff - {16'd0, m1_ff};
      dneg = m2 < m1_ff;
      yneg = dy[32];
      y1x  = {{5{y1_ff[31]}}, y1_ff};
      qx   = {2'd0, div_rsp.quotient};
   end

   always_comb begin
      state_in    = state_ff;
      units_in    = units_ff;
      mode_in     = mode_ff;
      num_in      = num_ff;
      cur_in      = cur_ff;
      j_in        = j_ff;
      last_end_in = last_end_ff;
      tl_in       = tl_ff;
      m1_in       = m1_ff;
      y1_in       = y1_ff;
      dmag_in     = dmag_ff;
      neg_in      = neg_ff;
      y_in        = y_ff;
      last_in     = last_ff;
      status_in   = status_ff;
      acc_in      = acc_ff;
      mcand_in    = mcand_ff;
      mplier_in   = mplier_ff;
      mcnt_in     = mcnt_ff;
      cidx_in     = cidx_ff;
      cs_in       = cs_ff;
      ce_in       = ce_ff;
      cv_in       = cv_ff;
      kr_in       = kr_ff;
      rd_addr     = cur_ff;
      mem_we      = 1'b0;

      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_we) begin
         case (csr_index)
            fgr_pkg::CSR_UNITS: units_in = csr_wdata;
            fgr_pkg::CSR_MODE:  mode_in  = csr_wdata[0];
            default:            units_in = units_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               case (req.kind)
                  fgr_pkg::KIND_LOAD: begin
                     if (num_ff < NUM_W'(MAX_FRAMES)) begin
                        mem_we      = 1'b1;
                        num_in      = num_ff + 1'b1;
                        last_end_in = req.frame_end;
                     end
                  end
                  fgr_pkg::KIND_CLEAR: begin
                     num_in = '0;
                     cur_in = '0;
                     j_in   = '0;
                  end
                  fgr_pkg::KIND_SAMPLE: begin
                     tl_in   = {j_ff, 1'b1} * r_eff;
                     y_in    = '0;
                     last_in = 1'b0;
                     if (num_ff == '0 ||
                         (mode_ff == fgr_pkg::MODE_LINEAR && num_ff == NUM_W'(1))) begin
                        status_in = fgr_pkg::ST_FEW;
                        state_in  = S_FIN;
                     end else begin
                        state_in = S_CHK;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         // j < Nint  <=>  (2j+1)R <= 2E ; last  <=>  (2j+3)R > 2E
         S_CHK: begin
            if (tl_ff > {16'd0, e2}) begin
               status_in = fgr_pkg::ST_EXHAUSTED;
               state_in  = S_FIN;
            end else begin
               status_in = fgr_pkg::ST_OK;
               last_in   = ({1'b0, tl_ff} + {33'd0, r2}) > {17'd0, e2};
               cidx_in   = num_ff;
               state_in  = (mode_ff == fgr_pkg::MODE_CONST) ? S_CRD : S_LRD;
            end
         end
         S_LRD: begin
            if (cur_p2 < (NUM_W+1)'(num_ff)) begin
               rd_addr  = cur_ff + 1'b1;
               state_in = S_LCMP;
            end else begin
               rd_addr  = cur_ff;
               state_in = S_LV1;
            end
         end
         S_LCMP: begin
            if (tl_ff > {16'd0, m_rd}) begin
               cur_in   = cur_ff + 1'b1;
               state_in = S_LRD;
            end else begin
               rd_addr  = cur_ff;
               state_in = S_LV1;
            end
         end
         S_LV1: begin
            m1_in    = m_rd;
            y1_in    = rd_ff[95:64];
            rd_addr  = cur_ff + 1'b1;
            state_in = S_LV2;
         end
         S_LV2: begin
            if (m2 == m1_ff || dy == '0 || tl_ff == {16'd0, m1_ff}) begin
               y_in     = y1x;
               state_in = S_FIN;
            end else begin
               neg_in    = nneg ^ dneg ^ yneg;
               dmag_in   = dneg ? {1'b0, m1_ff - m2} : {1'b0, m2 - m1_ff};
               mplier_in = yneg ? 32'(-dy) : dy[31:0];
               mcand_in  = {32'd0, nmag};
               acc_in    = '0;
               mcnt_in   = '0;
               state_in  = S_LMUL;
            end
         end
         S_LMUL: begin
            if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
            mcand_in  = {mcand_ff[79:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[31:1]};
            mcnt_in   = mcnt_ff + 1'b1;
            if (mcnt_ff == 5'd31) state_in = S_LDIVS;
         end
         S_LDIVS: state_in = S_LDIV;
         S_LDIV: begin
            if (div_rsp.done) begin
               if (neg_ff) begin
                  y_in = y1x - qx - {36'd0,
                         (div_rsp.inexact && div_rsp.quotient < fgr_pkg::QCAP)};
               end else begin
                  y_in = y1x + qx;
               end
               state_in = S_FIN;
            end
         end
         S_CRD: begin
            if (cidx_ff == '0) begin
               y_in     = '0;
               state_in = S_FIN;
            end else begin
               cidx_in  = cidx_ff - 1'b1;
               rd_addr  = IDX_W'(cidx_ff - 1'b1);
               state_in = S_CCHK;
            end
         end
         S_CCHK: begin
            if ({17'd0, s2} >= lim) begin
               state_in = S_CRD;
            end else if (!need_div) begin
               if (s_rd <= rd_ff[63:32]) begin
                  y_in     = {{5{rd_ff[95]}}, rd_ff[95:64]};
                  state_in = S_FIN;
               end else begin
                  state_in = S_CRD;
               end
            end else begin
               cs_in    = s_rd;
               ce_in    = rd_ff[63:32];
               cv_in    = rd_ff[95:64];
               state_in = S_CDIV;
            end
         end
         S_CDIV: begin
            if (div_rsp.done) begin
               kr_in    = div_rsp.quotient * r_eff;
               state_in = S_CCMP;
            end
         end
         S_CCMP: begin
            if (({19'd0, cs_ff} + kr_ff) <= {19'd0, ce_ff}) begin
               y_in     = {{5{cv_ff[31]}}, cv_ff};
               state_in = S_FIN;
            end else begin
               state_in = S_CRD;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = j_ff;
               rsp_status_in = status_ff;
               rsp_last_in   = (status_ff == fgr_pkg::ST_OK) && last_ff;
               if (status_ff != fgr_pkg::ST_OK || y_ff[36]) begin
                  rsp_value_in = '0;
               end else if (y_ff[35:31] != '0) begin
                  rsp_value_in = 31'h7FFF_FFFF;
               end else begin
                  rsp_value_in = y_ff[30:0];
               end
               if (status_ff == fgr_pkg::ST_OK) j_in = j_ff + 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[num_ff[IDX_W-1:0]] <= {req.frame_value, req.frame_end, req.frame_start};
      end
      rd_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         units_ff     <= 16'd1;
         mode_ff      <= fgr_pkg::MODE_LINEAR;
         num_ff       <= '0;
         cur_ff       <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         units_ff     <= units_in;
         mode_ff      <= mode_in;
         num_ff       <= num_in;
         cur_ff       <= cur_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_end_ff   <= last_end_in;
      tl_ff         <= tl_in;
      m1_ff         <= m1_in;
      y1_ff         <= y1_in;
      dmag_ff       <= dmag_in;
      neg_ff        <= neg_in;
      y_ff          <= y_in;
      last_ff       <= last_in;
      status_ff     <= status_in;
      acc_ff        <= acc_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      mcnt_ff       <= mcnt_in;
      cidx_ff       <= cidx_in;
      cs_ff         <= cs_in;
      ce_ff         <= ce_in;
      cv_ff         <= cv_in;
      kr_ff         <= kr_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.sample_value = rsp_value_ff;
   assign rsp.sample_index = rsp_index_ff;
   assign rsp.last_sample  = rsp_last_ff;
   assign rsp.status       = rsp_status_ff;

   a_num_cap: assert property (@(posedge clock) disable iff (reset)
      num_ff <= NUM_W'(MAX_FRAMES))
      else $error("frame count above capacity");

   a_pair_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LV1 |-> (NUM_W+1)'(cur_ff) + (NUM_W+1)'(1) < (NUM_W+1)'(num_ff))
      else $error("interpolation pair beyond loaded frames");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> (state_ff == S_LDIV || state_ff == S_CDIV))
      else $error("divider started outside a wait state");

   a_fin_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && slot_free) |=> (rsp_valid_ff &&
       (rsp_status_ff == fgr_pkg::ST_OK || rsp_value_ff == '0)))
      else $error("failed request carries a value");

endmodule

// ===== sv/fgr_divider.sv =====
// -----------------------------------------------------------------------------
// fgr_divider
// Restoring divider, one quotient bit per cycle, quotient saturated at QCAP.
// -----------------------------------------------------------------------------
module fgr_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  fgr_pkg::fgr_div_req_type div_req,
   output fgr_pkg::fgr_div_rsp_type div_rsp
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [fgr_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [fgr_pkg::DVD_W-1:0]   dvd_ff, dvd_in;
   logic [fgr_pkg::DVS_W-1:0]   dvs_ff, dvs_in;
   logic [fgr_pkg::DVS_W-1:0]   rem_ff, rem_in;
   logic [fgr_pkg::QUO_W-1:0]   quo_ff, quo_in;
   logic [fgr_pkg::DVS_W:0]     rem_sh;
   logic                        ge;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[fgr_pkg::DVD_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = fgr_pkg::CNT_W'(fgr_pkg::DVD_W - 1);
         dvd_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? fgr_pkg::DVS_W'(rem_sh - {1'b0, dvs_ff})
                     : rem_sh[fgr_pkg::DVS_W-1:0];
         quo_in = (quo_ff >= fgr_pkg::QCAP) ? fgr_pkg::QCAP
                                            : {quo_ff[fgr_pkg::QUO_W-2:0], ge};
         dvd_in = {dvd_ff[fgr_pkg::DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
   assign div_rsp.inexact  = rem_ff != '0;

endmodule
